[hdl/matrix_inverse_3x3_macros.svh]
// Assertion macros shared by the checker of the 3x3 matrix inverse.
// Depends on nothing; included by the checker file.
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MI3_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("matrix inverse check failed");

// Next-cycle implication, disabled while reset is high.
`define MI3_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("matrix inverse check failed");

// Next-cycle implication that is also checked across reset.
`define MI3_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("matrix inverse check failed");

`endif

[hdl/mi3_pkg.sv]
// Package of the 3x3 matrix inverse: widths, stage word types, saturation helper.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mi3_pkg;

   localparam int FRAC_BITS = 16;
   localparam int SHIFT     = 2 * FRAC_BITS;

   localparam int EL_W   = 32;
   localparam int PROD_W = 2 * EL_W;
   localparam int COF_W  = PROD_W + 1;
   localparam int CMAG_W = PROD_W;
   localparam int PART_W = COF_W;
   localparam int SUM_W  = PART_W + 2;
   localparam int DET_W  = EL_W + COF_W;
   localparam int DMAG_W = DET_W - 1;
   localparam int NUM_W  = CMAG_W + SHIFT;
   localparam int Q_W    = EL_W;
   localparam int DSH_W  = DMAG_W + Q_W - 1;
   localparam int EPS_W  = 16;

   localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(7);
   localparam logic [EL_W-1:0]  SAT_POS   = {1'b0, {(EL_W-1){1'b1}}};
   localparam logic [EL_W-1:0]  SAT_NEG   = {1'b1, {(EL_W-1){1'b0}}};

   typedef struct packed {
      logic [8:0][COF_W-1:0] cof;
      logic [2:0][EL_W-1:0]  row0;
   } cof_word_type;

   typedef struct packed {
      logic [8:0][NUM_W-1:0] rem;
      logic [8:0][Q_W-1:0]   quo;
      logic [8:0]            qneg;
      logic [DSH_W-1:0]      dsh;
      logic                  sing;
      logic [EL_W-1:0]       det;
   } div_word_type;

   function automatic logic [EL_W-1:0] sat_word(input logic neg, input logic ovf,
                                                input logic [EL_W-1:0] mag);
      logic [EL_W-1:0] r;
      if (ovf) begin
         r = neg ? SAT_NEG : SAT_POS;
      end else if (neg) begin
         r = -mag;
      end else begin
         r = mag;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hdl/mi3_cof.sv]
// Two pipeline stages: the eighteen 2x2 products, then the nine cofactors.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mi3_cof (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             up_valid,
   input  wire logic [8:0][mi3_pkg::EL_W-1:0]    up_m,
   output logic                                  hold_out,
   output logic                                  down_valid,
   input  wire logic                             down_hold,
   output mi3_pkg::cof_word_type                 down_word
);

   logic [17:0][mi3_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [2:0][mi3_pkg::EL_W-1:0]    row0_ff;
   logic                             valid1_ff, valid2_ff;
   logic                             hold1, hold2;
   mi3_pkg::cof_word_type            word_ff, word_in;

   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int R1 = (i + 1) % 3;
         localparam int R2 = (i + 2) % 3;
         localparam int C1 = (j + 1) % 3;
         localparam int C2 = (j + 2) % 3;
         logic signed [mi3_pkg::PROD_W-1:0] pa, pb;
         assign pa = $signed(up_m[R1*3+C1]) * $signed(up_m[R2*3+C2]);
         assign pb = $signed(up_m[R1*3+C2]) * $signed(up_m[R2*3+C1]);
         assign prod_in[2*(i*3+j)]   = pa;
         assign prod_in[2*(i*3+j)+1] = pb;
      end
   end

   always_comb begin
      word_in.row0 = row0_ff;
      for (int k = 0; k < 9; k++) begin
         word_in.cof[k] = {prod_ff[2*k][mi3_pkg::PROD_W-1], prod_ff[2*k]}
                        - {prod_ff[2*k+1][mi3_pkg::PROD_W-1], prod_ff[2*k+1]};
      end
   end

   assign hold2    = valid2_ff && down_hold;
   assign hold1    = valid1_ff && hold2;
   assign hold_out = hold1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         if (!hold1) valid1_ff <= up_valid;
         if (!hold2) valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold1) begin
         prod_ff <= prod_in;
         row0_ff <= up_m[2:0];
      end
      if (!hold2) word_ff <= word_in;
   end

   assign down_valid = valid2_ff;
   assign down_word  = word_ff;

endmodule

`default_nettype wire

[hdl/mi3_det.sv]
// Four pipeline stages: determinant partial products, partial sums, the full
// determinant, then magnitude, singular test and divider setup. Depends on mi3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mi3_det (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [mi3_pkg::EPS_W-1:0]     eps,
   input  wire logic                          up_valid,
   input  wire mi3_pkg::cof_word_type         up_word,
   output logic                               hold_out,
   output logic                               down_valid,
   input  wire logic                          down_hold,
   output mi3_pkg::div_word_type              down_word
);

   logic [3:0] valid_ff;
   logic [3:0] hold;

   logic signed [mi3_pkg::PART_W-1:0] lo_ff [3];
   logic signed [mi3_pkg::PART_W-1:0] hi_ff [3];
   logic signed [mi3_pkg::PART_W-1:0] lo_in [3];
   logic signed [mi3_pkg::PART_W-1:0] hi_in [3];
   logic [8:0][mi3_pkg::CMAG_W-1:0]   cmag_c_ff, cmag_d_ff, cmag_e_ff, cmag_in;
   logic [8:0]                        cneg_c_ff, cneg_d_ff, cneg_e_ff, cneg_in;
   logic signed [mi3_pkg::SUM_W-1:0]  slo_ff, shi_ff, slo_in, shi_in;
   logic signed [mi3_pkg::DET_W-1:0]  det_ff, det_in;
   mi3_pkg::div_word_type             word_ff, word_in;

   // The 65-bit cofactor is split into an unsigned low half and a signed high
   // half so that each product stays near 32 by 32 bits.
   for (genvar j = 0; j < 3; j++) begin : g_part
      assign lo_in[j] = $signed(up_word.row0[j])
                      * $signed({1'b0, up_word.cof[j][mi3_pkg::EL_W-1:0]});
      assign hi_in[j] = $signed(up_word.row0[j])
                      * $signed(up_word.cof[j][mi3_pkg::COF_W-1:mi3_pkg::EL_W]);
   end

   for (genvar k = 0; k < 9; k++) begin : g_mag
      logic [mi3_pkg::COF_W-1:0] neg_c;
      assign neg_c      = -up_word.cof[k];
      assign cneg_in[k] = up_word.cof[k][mi3_pkg::COF_W-1];
      assign cmag_in[k] = cneg_in[k] ? neg_c[mi3_pkg::CMAG_W-1:0]
                                     : up_word.cof[k][mi3_pkg::CMAG_W-1:0];
   end

   assign slo_in = mi3_pkg::SUM_W'(lo_ff[0]) + mi3_pkg::SUM_W'(lo_ff[1])
                 + mi3_pkg::SUM_W'(lo_ff[2]);
   assign shi_in = mi3_pkg::SUM_W'(hi_ff[0]) + mi3_pkg::SUM_W'(hi_ff[1])
                 + mi3_pkg::SUM_W'(hi_ff[2]);
   assign det_in = mi3_pkg::DET_W'(slo_ff) + (mi3_pkg::DET_W'(shi_ff) <<< mi3_pkg::EL_W);

   always_comb begin
      logic                        dneg;
      logic [mi3_pkg::DET_W-1:0]   det_neg;
      logic [mi3_pkg::DET_W-1:0]   dmag_full;
      logic [mi3_pkg::DMAG_W-1:0]  dmag;
      logic [mi3_pkg::DMAG_W-1:0]  lim;
      logic [mi3_pkg::DMAG_W-1:0]  dhi;
      dneg      = det_ff[mi3_pkg::DET_W-1];
      det_neg   = -det_ff;
      dmag_full = dneg ? det_neg : det_ff;
      dmag      = dmag_full[mi3_pkg::DMAG_W-1:0];
      lim       = mi3_pkg::DMAG_W'({eps, {mi3_pkg::SHIFT{1'b0}}});
      dhi       = dmag >> mi3_pkg::SHIFT;
      word_in.sing = (dmag <= lim);
      word_in.det  = mi3_pkg::sat_word(dneg, |dhi[mi3_pkg::DMAG_W-1:mi3_pkg::EL_W-1],
                                       dhi[mi3_pkg::EL_W-1:0]);
      // The divisor starts aligned to the top quotient bit, which flags overflow.
      word_in.dsh  = mi3_pkg::DSH_W'(dmag) << (mi3_pkg::Q_W - 1);
      // Lane i*3+j divides the transposed cofactor, giving the adjugate.
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            word_in.rem[i*3+j]  = {cmag_e_ff[j*3+i], {mi3_pkg::SHIFT{1'b0}}};
            word_in.quo[i*3+j]  = '0;
            word_in.qneg[i*3+j] = cneg_e_ff[j*3+i] ^ dneg;
         end
      end
   end

   always_comb begin
      hold[3] = valid_ff[3] && down_hold;
      for (int s = 2; s >= 0; s--) begin
         hold[s] = valid_ff[s] && hold[s+1];
      end
   end
   assign hold_out = hold[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (!hold[0]) valid_ff[0] <= up_valid;
         for (int s = 1; s < 4; s++) begin
            if (!hold[s]) valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!hold[0]) begin
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         cmag_c_ff <= cmag_in;
         cneg_c_ff <= cneg_in;
      end
      if (!hold[1]) begin
         slo_ff    <= slo_in;
         shi_ff    <= shi_in;
         cmag_d_ff <= cmag_c_ff;
         cneg_d_ff <= cneg_c_ff;
      end
      if (!hold[2]) begin
         det_ff    <= det_in;
         cmag_e_ff <= cmag_d_ff;
         cneg_e_ff <= cneg_d_ff;
      end
      if (!hold[3]) word_ff <= word_in;
   end

   assign down_valid = valid_ff[3];
   assign down_word  = word_ff;

endmodule

`default_nettype wire

[hdl/mi3_div_step.sv]
// One restoring division stage for all nine quotient lanes: one compare and
// subtract per lane, one quotient bit. Depends on mi3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mi3_div_step (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   up_valid,
   input  wire mi3_pkg::div_word_type  up_word,
   output logic                        hold_out,
   output logic                        down_valid,
   input  wire logic                   down_hold,
   output mi3_pkg::div_word_type       down_word
);

   logic                  valid_ff;
   logic                  hold;
   mi3_pkg::div_word_type word_ff, word_in;

   always_comb begin
      logic [mi3_pkg::DSH_W-1:0] r_ext;
      logic [mi3_pkg::DSH_W-1:0] diff;
      word_in     = up_word;
      word_in.dsh = up_word.dsh >> 1;
      for (int k = 0; k < 9; k++) begin
         r_ext = mi3_pkg::DSH_W'(up_word.rem[k]);
         diff  = r_ext - up_word.dsh;
         if (r_ext >= up_word.dsh) begin
            word_in.rem[k] = diff[mi3_pkg::NUM_W-1:0];
            word_in.quo[k] = {up_word.quo[k][mi3_pkg::Q_W-2:0], 1'b1};
         end else begin
            word_in.quo[k] = {up_word.quo[k][mi3_pkg::Q_W-2:0], 1'b0};
         end
      end
   end

   assign hold     = valid_ff && down_hold;
   assign hold_out = hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!hold) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) word_ff <= word_in;
   end

   assign down_valid = valid_ff;
   assign down_word  = word_ff;

endmodule

`default_nettype wire

[hdl/matrix_inverse_3x3.sv]
// Top level of the 3x3 matrix inverse by the adjugate method, Q16.16 fixed point.
// Depends on mi3_pkg, mi3_cof, mi3_det and mi3_div_step.
//
//   channel   ports            direction   moves
//   request   req_*            in          one matrix word, nine elements
//   response  rsp_*            out         one inverse word, det and singular flag
//   config    csr_wr_*         in          singular epsilon, 16 bits
//
// One word enters per cycle while req_stall is low. It passes two cofactor stages, four
// determinant stages, 32 divider stages (one quotient bit each) and the output register.
// Reset is synchronous and clears the valid bits and sets epsilon to 7.
// Each stage holds only while it is full and the one after it holds, so bubbles
// fill while the output waits and no word is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module matrix_inverse_3x3 (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [mi3_pkg::EPS_W-1:0]   csr_wr_data,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [mi3_pkg::EL_W-1:0]    req_a_00,
   input  wire logic [mi3_pkg::EL_W-1:0]    req_a_01,
   input  wire logic [mi3_pkg::EL_W-1:0]    req_a_02,
   input  wire logic [mi3_pkg::EL_W-1:0]    req_a_10,
   input  wire logic [mi3_pkg::EL_W-1:0]    req_a_11,
   input  wire logic [mi3_pkg::EL_W-1:0]    req_a_12,
   input  wire logic [mi3_pkg::EL_W-1:0]    req_a_20,
   input  wire logic [mi3_pkg::EL_W-1:0]    req_a_21,
   input  wire logic [mi3_pkg::EL_W-1:0]    req_a_22,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [mi3_pkg::EL_W-1:0]         rsp_inv_00,
   output logic [mi3_pkg::EL_W-1:0]         rsp_inv_01,
   output logic [mi3_pkg::EL_W-1:0]         rsp_inv_02,
   output logic [mi3_pkg::EL_W-1:0]         rsp_inv_10,
   output logic [mi3_pkg::EL_W-1:0]         rsp_inv_11,
   output logic [mi3_pkg::EL_W-1:0]         rsp_inv_12,
   output logic [mi3_pkg::EL_W-1:0]         rsp_inv_20,
   output logic [mi3_pkg::EL_W-1:0]         rsp_inv_21,
   output logic [mi3_pkg::EL_W-1:0]         rsp_inv_22,
   output logic [mi3_pkg::EL_W-1:0]         rsp_det,
   output logic                             rsp_singular
);

   logic [mi3_pkg::EPS_W-1:0]     eps_ff;
   logic [8:0][mi3_pkg::EL_W-1:0] req_m;

   logic                          cof_valid, cof_hold;
   mi3_pkg::cof_word_type         cof_word;

   logic [mi3_pkg::Q_W:0]         dv_valid, dv_hold;
   mi3_pkg::div_word_type         dv_word [mi3_pkg::Q_W+1];

   logic                          rsp_valid_ff, hold_o;
   logic [8:0][mi3_pkg::EL_W-1:0] inv_ff, inv_in;
   logic [mi3_pkg::EL_W-1:0]      det_ff;
   logic                          sing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= mi3_pkg::EPS_RESET;
      end else if (csr_wr_en) begin
         eps_ff <= csr_wr_data;
      end
   end

   assign req_m = {req_a_22, req_a_21, req_a_20, req_a_12, req_a_11, req_a_10,
                   req_a_02, req_a_01, req_a_00};

   mi3_cof u_cof (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_m       (req_m),
      .hold_out   (req_stall),
      .down_valid (cof_valid),
      .down_hold  (cof_hold),
      .down_word  (cof_word)
   );

   mi3_det u_det (
      .clock      (clock),
      .reset      (reset),
      .eps        (eps_ff),
      .up_valid   (cof_valid),
      .up_word    (cof_word),
      .hold_out   (cof_hold),
      .down_valid (dv_valid[0]),
      .down_hold  (dv_hold[0]),
      .down_word  (dv_word[0])
   );

   for (genvar s = 0; s < mi3_pkg::Q_W; s++) begin : g_div
      mi3_div_step u_step (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (dv_valid[s]),
         .up_word    (dv_word[s]),
         .hold_out   (dv_hold[s]),
         .down_valid (dv_valid[s+1]),
         .down_hold  (dv_hold[s+1]),
         .down_word  (dv_word[s+1])
      );
   end

   assign hold_o                = rsp_valid_ff && rsp_stall;
   assign dv_hold[mi3_pkg::Q_W] = hold_o;

   // The first quotient bit shifted in marks a quotient of at least one half range.
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         if (dv_word[mi3_pkg::Q_W].sing) begin
            inv_in[k] = '0;
         end else begin
            inv_in[k] = mi3_pkg::sat_word(dv_word[mi3_pkg::Q_W].qneg[k],
                                          dv_word[mi3_pkg::Q_W].quo[k][mi3_pkg::Q_W-1],
                                          dv_word[mi3_pkg::Q_W].quo[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!hold_o) begin
         rsp_valid_ff <= dv_valid[mi3_pkg::Q_W];
      end
   end

   always_ff @(posedge clock) begin
      if (!hold_o) begin
         inv_ff  <= inv_in;
         det_ff  <= dv_word[mi3_pkg::Q_W].det;
         sing_ff <= dv_word[mi3_pkg::Q_W].sing;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_inv_00   = inv_ff[0];
   assign rsp_inv_01   = inv_ff[1];
   assign rsp_inv_02   = inv_ff[2];
   assign rsp_inv_10   = inv_ff[3];
   assign rsp_inv_11   = inv_ff[4];
   assign rsp_inv_12   = inv_ff[5];
   assign rsp_inv_20   = inv_ff[6];
   assign rsp_inv_21   = inv_ff[7];
   assign rsp_inv_22   = inv_ff[8];
   assign rsp_det      = det_ff;
   assign rsp_singular = sing_ff;

endmodule

`default_nettype wire

[hdl/mi3_checker.sv]
// Port-level checker for the 3x3 matrix inverse and its bind to the top level.
// Depends on mi3_pkg and matrix_inverse_3x3_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_inverse_3x3_macros.svh"

module mi3_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        csr_wr_en,
   input wire logic [mi3_pkg::EPS_W-1:0]   csr_wr_data,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic [mi3_pkg::EL_W-1:0]    req_a_00,
   input wire logic [mi3_pkg::EL_W-1:0]    req_a_01,
   input wire logic [mi3_pkg::EL_W-1:0]    req_a_02,
   input wire logic [mi3_pkg::EL_W-1:0]    req_a_10,
   input wire logic [mi3_pkg::EL_W-1:0]    req_a_11,
   input wire logic [mi3_pkg::EL_W-1:0]    req_a_12,
   input wire logic [mi3_pkg::EL_W-1:0]    req_a_20,
   input wire logic [mi3_pkg::EL_W-1:0]    req_a_21,
   input wire logic [mi3_pkg::EL_W-1:0]    req_a_22,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [mi3_pkg::EL_W-1:0]    rsp_inv_00,
   input wire logic [mi3_pkg::EL_W-1:0]    rsp_inv_01,
   input wire logic [mi3_pkg::EL_W-1:0]    rsp_inv_02,
   input wire logic [mi3_pkg::EL_W-1:0]    rsp_inv_10,
   input wire logic [mi3_pkg::EL_W-1:0]    rsp_inv_11,
   input wire logic [mi3_pkg::EL_W-1:0]    rsp_inv_12,
   input wire logic [mi3_pkg::EL_W-1:0]    rsp_inv_20,
   input wire logic [mi3_pkg::EL_W-1:0]    rsp_inv_21,
   input wire logic [mi3_pkg::EL_W-1:0]    rsp_inv_22,
   input wire logic [mi3_pkg::EL_W-1:0]    rsp_det,
   input wire logic                        rsp_singular
);

   // The input side can only back up when a finished word is waiting at the output.
   `MI3_ASSERT_IMP(a_stall_from_output, clock, reset, req_stall, rsp_valid && rsp_stall)

   // A singular word carries an all-zero inverse.
   `MI3_ASSERT_IMP(a_singular_zero, clock, reset, rsp_valid && rsp_singular,
      rsp_inv_00 == '0 && rsp_inv_01 == '0 && rsp_inv_02 == '0 && rsp_inv_10 == '0 &&
      rsp_inv_11 == '0 && rsp_inv_12 == '0 && rsp_inv_20 == '0 && rsp_inv_21 == '0 &&
      rsp_inv_22 == '0)

   // A stalled result word stays put.
   `MI3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_det) && $stable(rsp_singular) && $stable(rsp_inv_00) &&
      $stable(rsp_inv_11) && $stable(rsp_inv_22))

   // The pipeline comes out of reset empty.
   `MI3_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && !req_stall)

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (.*);

`default_nettype wire

[bench/matrix_inverse_3x3_tb.sv]
// Self-checking testbench of the 3x3 matrix inverse: directed and random matrices.
// Depends on mi3_pkg and the matrix_inverse_3x3 RTL; expected words come from an exact function.
`timescale 1ns / 1ps
`default_nettype none

module matrix_inverse_3x3_tb;

   typedef logic [8:0][mi3_pkg::EL_W-1:0] matrix_type;
   typedef struct packed {
      logic [8:0][mi3_pkg::EL_W-1:0] inv;
      logic [mi3_pkg::EL_W-1:0]      det;
      logic                          singular;
   } inverse_type;

   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 45;
   localparam int STUCK_LIMIT = 5000;
   localparam logic [mi3_pkg::EL_W-1:0] ONE = 32'h0001_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [mi3_pkg::EPS_W-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   matrix_type req_m = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   inverse_type rsp_word;

   logic [mi3_pkg::EPS_W-1:0] epsilon = mi3_pkg::EPS_RESET;
   inverse_type pending_inverses[$];
   int error_count = 0;
   int stuck_cycles = 0;
   bit no_idle = 1'b0;
   bit hold_request = 1'b0;

   always #1 clock = ~clock;

   matrix_inverse_3x3 u_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_00(req_m[0]), .req_a_01(req_m[1]), .req_a_02(req_m[2]),
      .req_a_10(req_m[3]), .req_a_11(req_m[4]), .req_a_12(req_m[5]),
      .req_a_20(req_m[6]), .req_a_21(req_m[7]), .req_a_22(req_m[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_inv_00(rsp_word.inv[0]), .rsp_inv_01(rsp_word.inv[1]),
      .rsp_inv_02(rsp_word.inv[2]), .rsp_inv_10(rsp_word.inv[3]),
      .rsp_inv_11(rsp_word.inv[4]), .rsp_inv_12(rsp_word.inv[5]),
      .rsp_inv_20(rsp_word.inv[6]), .rsp_inv_21(rsp_word.inv[7]),
      .rsp_inv_22(rsp_word.inv[8]), .rsp_det(rsp_word.det),
      .rsp_singular(rsp_word.singular)
   );

   function automatic logic [mi3_pkg::EL_W-1:0] clamp_q16(input bit neg,
                                                          input logic [127:0] mag);
      if (neg) begin
         return (mag >= 128'h8000_0000) ? 32'h8000_0000 : mi3_pkg::EL_W'(-mag[31:0]);
      end
      return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
   endfunction

   // Exact adjugate inverse; all intermediates fit comfortably in 128 bits.
   function automatic inverse_type adjugate_inverse(input matrix_type m,
                                                    input logic [mi3_pkg::EPS_W-1:0] eps);
      inverse_type r;
      logic signed [127:0] e[9];
      logic signed [127:0] cof[9];
      logic signed [127:0] det;
      logic [127:0] dmag, cmag, limit;
      bit dneg;
      int r1, r2, c1, c2;
      for (int k = 0; k < 9; k++) e[k] = $signed(m[k]);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            r1 = (i + 1) % 3; r2 = (i + 2) % 3;
            c1 = (j + 1) % 3; c2 = (j + 2) % 3;
            cof[i*3+j] = e[r1*3+c1] * e[r2*3+c2] - e[r1*3+c2] * e[r2*3+c1];
         end
      end
      det = e[0] * cof[0] + e[1] * cof[1] + e[2] * cof[2];
      dneg = det < 0;
      dmag = dneg ? -det : det;
      limit = {112'b0, eps} << mi3_pkg::SHIFT;
      r.singular = dmag <= limit;
      r.det = clamp_q16(dneg, dmag >> mi3_pkg::SHIFT);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            r.inv[i*3+j] = '0;
            if (!r.singular) begin
               cmag = (cof[j*3+i] < 0) ? -cof[j*3+i] : cof[j*3+i];
               r.inv[i*3+j] = clamp_q16((cof[j*3+i] < 0) != dneg,
                                        (cmag << mi3_pkg::SHIFT) / dmag);
            end
         end
      end
      return r;
   endfunction

   task automatic send_matrix(input matrix_type m);
      req_valid <= 1'b1;
      req_m <= m;
      do @(posedge clock); while (req_stall);
      pending_inverses.push_back(adjugate_inverse(m, epsilon));
      while (!no_idle && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (pending_inverses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_epsilon(input logic [mi3_pkg::EPS_W-1:0] value);
      req_valid <= 1'b0;
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      epsilon = value;
   endtask

   function automatic matrix_type diag(input logic [31:0] d0, d1, d2);
      matrix_type m = '0;
      m[0] = d0; m[4] = d1; m[8] = d2;
      return m;
   endfunction

   function automatic logic [mi3_pkg::EL_W-1:0] random_element();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return mi3_pkg::EL_W'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
         2: case ($urandom_range(0, 3))
               0: return mi3_pkg::SAT_POS;
               1: return mi3_pkg::SAT_NEG;
               2: return '0;
               default: return ONE;
            endcase
         default: return $urandom & $urandom & $urandom;
      endcase
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type m;
      for (int k = 0; k < 9; k++) m[k] = random_element();
      // Now and then force a dependent row so singular words show up.
      if ($urandom_range(0, 9) == 0) begin
         m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
      end
      return m;
   endfunction

   task automatic test_directed();
      matrix_type m;
      send_matrix(diag(ONE, ONE, ONE));
      send_matrix('0);
      send_matrix({9{mi3_pkg::SAT_NEG}});
      send_matrix({9{mi3_pkg::SAT_POS}});
      send_matrix(diag(mi3_pkg::SAT_NEG, mi3_pkg::SAT_NEG, mi3_pkg::SAT_NEG));
      send_matrix(diag(mi3_pkg::SAT_POS, mi3_pkg::SAT_NEG, mi3_pkg::SAT_POS));
      send_matrix(diag(32'd1, ONE, ONE));               // det within epsilon, singular
      send_matrix(diag(-32'sd1, ONE, ONE));
      send_matrix(diag(3 << 16, 3 << 16, 3 << 16));      // inexact quotient truncates
      send_matrix(diag(-(3 << 16), 3 << 16, 7 << 16));
      // Determinant exactly at the epsilon bound, then just above it.
      send_matrix(diag(ONE, ONE, 32'd7));
      send_matrix(diag(ONE, ONE, 32'd8));
      send_matrix(diag(-ONE, ONE, 32'd7));
      m = '0;
      m[1] = ONE; m[3] = ONE; m[8] = 2 << 16;            // permutation, negative det
      send_matrix(m);
      m = {9{ONE}};
      send_matrix(m);
      write_epsilon('0);
      // With zero epsilon only an exact zero determinant is singular.
      send_matrix(diag(32'd1, 32'd1, 32'd1));
      send_matrix('0);
      send_matrix(diag(ONE, ONE, 32'd1));
      write_epsilon(16'hFFFF);
      send_matrix(diag(ONE, ONE, 32'hFFFF));
      send_matrix(diag(ONE, ONE, 32'h1_0000));
      send_matrix(diag(ONE, -ONE, 32'h1_0000));
   endtask

   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 50) write_epsilon(mi3_pkg::EPS_W'($urandom));
         no_idle = (n >= 200 && n < 260);
         send_matrix(random_matrix());
      end
      no_idle = 1'b0;
   endtask

   task automatic test_backpressure();
      write_epsilon(mi3_pkg::EPS_RESET);
      hold_request = 1'b1;
      for (int n = 0; n < 120; n++) send_matrix(random_matrix());
   endtask

   // Receiver: random stall, a quiet stretch, and one long hold-off.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= !no_idle && $urandom_range(0, 99) < 33;
         end
      end
   end

   always @(posedge clock) begin
      inverse_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_inverses.size() == 0) begin
            $error("unexpected response word");
            error_count++;
         end else begin
            want = pending_inverses.pop_front();
            for (int k = 0; k < 9; k++) begin
               if (rsp_word.inv[k] !== want.inv[k]) begin
                  $error("inv_%0d%0d expected %h actual %h", k / 3, k % 3,
                         want.inv[k], rsp_word.inv[k]);
                  error_count++;
               end
            end
            if (rsp_word.det !== want.det) begin
               $error("det expected %h actual %h", want.det, rsp_word.det);
               error_count++;
            end
            if (rsp_word.singular !== want.singular) begin
               $error("singular expected %b actual %b", want.singular, rsp_word.singular);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(360);
      test_backpressure();
      req_valid <= 1'b0;
      wait_drained();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
